// ===== design/besr_pkg.sv =====
// Shared constants for the big-endian sized RAM: field widths and access codes.
package besr_pkg;

   localparam int MEM_BYTES_DEFAULT = 65536;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 17;
   localparam int WCODE_W = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [WCODE_W-1:0] WIDTH_BYTE = 2'd0;
   localparam logic [WCODE_W-1:0] WIDTH_HALF = 2'd1;
   localparam logic [WCODE_W-1:0] WIDTH_WORD = 2'd2;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage

// ===== design/big_endian_sized_ram_core.sv =====
// Byte-addressable big-endian RAM built from four byte-wide banks.
//
//   channel   ports                                   handshake
//   request   req_kind/access_width/address/write_data start & !busy
//   response  rsp_read_data, rsp_status               rsp_strobe, one cycle, no stall
//   config    csr_write_data                          csr_write_en
//
// One item per clock while busy is low; the result passes the bank read
// register, then is assembled into the output register. Any 1, 2 or 4
// byte access, aligned or not, touches each bank at most once, so one pass
// serves it. After reset the banks are swept to zero, one row of four
// bytes per cycle, through all (MEM_BYTES+3)/4 rows (16384 at the default
// size), with busy high. The receiver cannot stall; results are never held back.
module big_endian_sized_ram_core #(
   parameter int MEM_BYTES = besr_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [besr_pkg::WCODE_W-1:0]    req_access_width,
   input  logic [besr_pkg::ADDR_W-1:0]     req_address,
   input  logic [besr_pkg::DATA_W-1:0]     req_write_data,
   output logic                            rsp_strobe,
   output logic [besr_pkg::DATA_W-1:0]     rsp_read_data,
   output logic                            rsp_status,
   input  logic                            csr_write_en,
   input  logic [besr_pkg::SIZE_W-1:0]     csr_write_data
);

   localparam int DEPTH = (MEM_BYTES + 3) / 4;
   localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIM_W = ($clog2(MEM_BYTES + 1) > besr_pkg::SIZE_W) ?
                          $clog2(MEM_BYTES + 1) : besr_pkg::SIZE_W;
   localparam logic [LIM_W-1:0] MEM_LIM = LIM_W'(MEM_BYTES);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DEPTH - 1);
   localparam int BASE_W = besr_pkg::ADDR_W - 2;

   // configuration and clearing sweep
   logic [besr_pkg::SIZE_W-1:0] size_in_use_ff;
   logic                        clear_ff;
   logic [ROW_W-1:0]            clear_row_ff;

   // request decode
   logic                        accept;
   logic [2:0]                  nbytes;
   logic [besr_pkg::SIZE_W-1:0] end_addr;
   logic                        out_of_range;
   logic [1:0]                  offset;
   logic [BASE_W-1:0]           row_base;

   // bank ports
   logic [ROW_W-1:0] bank_row [4];
   logic             bank_we [4];
   logic [7:0]       bank_wdata [4];
   logic [7:0]       rd_data [4];

   // read stage
   logic       s1_valid_ff;
   logic       s1_read_ff;
   logic       s1_ok_ff;
   logic [2:0] s1_nbytes_ff;
   logic [1:0] s1_offset_ff;
   logic [besr_pkg::DATA_W-1:0] assembled;

   // response register
   logic                        rsp_strobe_ff;
   logic [besr_pkg::DATA_W-1:0] rsp_read_data_ff;
   logic                        rsp_status_ff;

   assign busy = clear_ff;
   assign accept = start & ~clear_ff;
   assign offset = req_address[1:0];
   assign row_base = req_address[besr_pkg::ADDR_W-1:2];

   always_comb begin
      priority if (req_access_width[1]) begin
         nbytes = 3'd4;
      end else if (req_access_width == besr_pkg::WIDTH_HALF) begin
         nbytes = 3'd2;
      end else begin
         nbytes = 3'd1;
      end
   end

   assign end_addr = besr_pkg::SIZE_W'(req_address) + besr_pkg::SIZE_W'(nbytes);
   // bound is the smaller of the register and the physical size
   assign out_of_range = (LIM_W'(end_addr) > LIM_W'(size_in_use_ff)) ||
                         (LIM_W'(end_addr) > MEM_LIM);

   always_comb begin
      logic [1:0]        idx;
      logic [1:0]        sel;
      logic [BASE_W:0]   row_sum;
      for (int b = 0; b < 4; b++) begin
         // byte position within the access that lands in bank b
         idx = 2'(b) - offset;
         sel = 2'(nbytes - 3'd1 - {1'b0, idx});
         row_sum = {1'b0, row_base} + (BASE_W + 1)'(2'(b) < offset);
         if (clear_ff) begin
            bank_row[b] = clear_row_ff;
            bank_we[b] = 1'b1;
            bank_wdata[b] = 8'h00;
         end else begin
            bank_row[b] = ROW_W'(row_sum);
            bank_we[b] = accept && (req_kind == besr_pkg::KIND_WRITE) &&
                         !out_of_range && ({1'b0, idx} < nbytes);
            bank_wdata[b] = req_write_data[8 * sel +: 8];
         end
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0] mem [DEPTH];
      logic [7:0] rd_q_ff;

      always_ff @(posedge clock) begin
         if (bank_we[b]) begin
            mem[bank_row[b]] <= bank_wdata[b];
         end
         rd_q_ff <= mem[bank_row[b]];
      end

      assign rd_data[b] = rd_q_ff;
   end

   always_comb begin
      logic [1:0] bank;
      assembled = '0;
      for (int k = 0; k < 4; k++) begin
         // output byte k (k = 0 least significant) comes from the k-th byte address back from the last
         bank = s1_offset_ff + 2'(s1_nbytes_ff - 3'd1 - 3'(k));
         if (3'(k) < s1_nbytes_ff) begin
            assembled[8 * k +: 8] = rd_data[bank];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_in_use_ff <= besr_pkg::SIZE_RESET;
         clear_ff <= 1'b1;
         clear_row_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            size_in_use_ff <= csr_write_data;
         end
         if (clear_ff) begin
            clear_row_ff <= clear_row_ff + ROW_W'(1);
            if (clear_row_ff == LAST_ROW) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff <= (req_kind == besr_pkg::KIND_READ);
      s1_ok_ff <= !out_of_range;
      s1_nbytes_ff <= nbytes;
      s1_offset_ff <= offset;
      rsp_read_data_ff <= (s1_read_ff && s1_ok_ff) ? assembled : '0;
      rsp_status_ff <= s1_ok_ff ? besr_pkg::STATUS_OK : besr_pkg::STATUS_RANGE;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== design/besr_checker.sv =====
// Port-level checks on the big-endian sized RAM, bound to its top level.
module besr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_kind,
   input logic                            rsp_strobe,
   input logic [besr_pkg::DATA_W-1:0]     rsp_read_data,
   input logic                            rsp_status
);

   // every accepted item is answered by a result strobe
   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == besr_pkg::STATUS_RANGE)) |-> (rsp_read_data == '0))
      else $error("failed access returned data");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_kind, 2) == besr_pkg::KIND_WRITE)) |->
      (rsp_read_data == '0))
      else $error("write returned data");

   // clearing sweep starts straight out of reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy after reset");

endmodule

bind big_endian_sized_ram_core besr_checker u_besr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_kind      (req_kind),
   .rsp_strobe    (rsp_strobe),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status)
);
